[rtl/fgr_pkg.sv]
// shared types, constants and the 5x8 font table for the glyph framebuffer
package fgr_pkg;

  // panel defaults
  localparam int unsigned PanelWidthDef  = 128;
  localparam int unsigned PanelHeightDef = 64;

  // font geometry
  localparam int unsigned FirstCode = 32;
  localparam int unsigned LastCode  = 90;
  localparam int unsigned GlyphCols = 5;
  localparam int unsigned GlyphRows = 8;
  localparam int unsigned NumGlyphs = LastCode - FirstCode + 1;

  // register reset values
  localparam logic [6:0] OffsetXRst  = 7'd28;
  localparam logic [5:0] OffsetYRst  = 6'd24;
  localparam logic [7:0] VisWidthRst = 8'd72;
  localparam logic [6:0] VisHeightRst = 7'd40;

  // register indexes
  localparam logic [1:0] RegOffsetX   = 2'd0;
  localparam logic [1:0] RegOffsetY   = 2'd1;
  localparam logic [1:0] RegVisWidth  = 2'd2;
  localparam logic [1:0] RegVisHeight = 2'd3;

  // command codes
  typedef enum logic [1:0] {
    FUNC_DRAW   = 2'd0,
    FUNC_SCALED = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_RD,
    ST_WR,
    ST_RDB,
    ST_DONE
  } state_e;

  // font columns, bit n is row n
  localparam logic [7:0] FONT_TBL [0:NumGlyphs-1][0:GlyphCols-1] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h08,8'h2A,8'h1C,8'h2A,8'h08}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h00,8'h08,8'h14,8'h22,8'h41}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h41,8'h22,8'h14,8'h08,8'h00}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h32,8'h49,8'h79,8'h41,8'h3E}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h01,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h04,8'h02,8'h7F},
    '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h7F,8'h20,8'h18,8'h20,8'h7F},
    '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h03,8'h04,8'h78,8'h04,8'h03},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}
  };

  // one font column; codes without a glyph give the space, columns past the glyph give 0
  function automatic logic [7:0] font_col(input logic [7:0] code, input logic [2:0] col);
    logic [7:0] idx;
    logic [7:0] res;
    idx = 8'd0;
    if (code >= 8'(FirstCode) && code <= 8'(LastCode)) begin
      idx = code - 8'(FirstCode);
    end
    res = 8'd0;
    if (col < 3'(GlyphCols)) begin
      res = FONT_TBL[idx[5:0]][col];
    end
    return res;
  endfunction

endpackage

[rtl/fgr_in_if.sv]
// request channel: command, glyph code, position and read address
interface fgr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_code;
  logic [6:0] x_pos;
  logic [5:0] y_pos;
  logic [9:0] read_address;

  modport source (output valid, func, char_code, x_pos, y_pos, read_address, input ready);
  modport sink   (input valid, func, char_code, x_pos, y_pos, read_address, output ready);
endinterface

[rtl/fgr_out_if.sv]
// result channel: read byte and status
interface fgr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

[rtl/fgr_store.sv]
// framebuffer memory with a masked read-modify-write merge
module fgr_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic [Aw-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  input  logic          wr_en_i,
  input  logic [Aw-1:0] wr_addr_i,
  input  logic [7:0]    wr_mask_i,
  input  logic [7:0]    wr_bits_i
);

  logic [7:0] mem [Depth];
  logic [7:0] rd_q;

  // registered read
  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  // write back the byte read in the previous cycle, masked bits replaced
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= (rd_q & ~wr_mask_i) | (wr_bits_i & wr_mask_i);
    end
  end

  assign rd_data_o = rd_q;

endmodule

[rtl/font_glyph_framebuffer_render_top.sv]
// top level of the glyph framebuffer renderer
// One request is worked at a time. A draw reads and writes back each touched
// byte in turn, ST_RD then ST_WR (one memory read port, one write port):
// 5 columns over two pages for a normal glyph, 6 for a scaled one. A skipped
// draw or out-of-range read goes straight to ST_DONE; a read passes ST_RDB
// first. Clear sweeps the store one byte a cycle, all PANEL_WIDTH*PANEL_HEIGHT/8
// bytes; the same sweep runs after reset, during which no request is accepted.
// PANEL_HEIGHT is taken as a multiple of 8. Configuration may be written any time.
module font_glyph_framebuffer_render_top #(
  parameter int unsigned PANEL_WIDTH  = fgr_pkg::PanelWidthDef,
  parameter int unsigned PANEL_HEIGHT = fgr_pkg::PanelHeightDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  fgr_in_if.sink     in_i,
  fgr_out_if.source  out_o
);

  localparam int unsigned StoreBytes = PANEL_WIDTH * PANEL_HEIGHT / 8;
  localparam int unsigned Aw = $clog2(StoreBytes);

  fgr_pkg::state_e state_q, state_d;

  logic [6:0] off_x_q;
  logic [5:0] off_y_q;
  logic [7:0] vis_w_q;
  logic [6:0] vis_h_q;

  logic          scaled_q;
  logic [7:0]    code_q;
  logic [8:0]    bx_q;
  logic [6:0]    by_q;
  logic [2:0]    k_q;
  logic          p_q;
  logic [Aw-1:0] cnt_q;
  logic          clr_res_q;
  logic          op_ok_q;
  logic [Aw-1:0] op_addr_q;
  logic [7:0]    op_mask_q;
  logic [7:0]    op_bits_q;
  logic [7:0]    res_data_q;
  logic          res_status_q;
  logic          out_valid_q;
  logic [7:0]    out_data_q;
  logic          out_status_q;

  logic          in_acc;
  logic          skip;
  logic          rd_in_range;
  logic [31:0]   in_addr_ext;
  logic          last_op;
  logic          out_free;

  logic [8:0]    col;
  logic [4:0]    page;
  logic [7:0]    g0, g1, v;
  logic [8:0]    v9;
  logic [15:0]   b16, m16;
  logic [7:0]    pg_b, pg_m, row_ok;
  logic [31:0]   pos;
  logic          op_ok;

  logic [Aw-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [Aw-1:0] wr_addr;
  logic [7:0]    wr_mask, wr_bits;

  assign in_acc      = in_i.valid && in_i.ready;
  assign skip        = ({1'b0, in_i.x_pos} >= vis_w_q) || ({1'b0, in_i.y_pos} >= vis_h_q);
  assign in_addr_ext = {22'd0, in_i.read_address};
  assign rd_in_range = in_addr_ext < StoreBytes;
  assign last_op     = p_q && (k_q == (scaled_q ? 3'd5 : 3'd4));
  assign out_free    = !out_valid_q || out_o.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= fgr_pkg::OffsetXRst;
      off_y_q <= fgr_pkg::OffsetYRst;
      vis_w_q <= fgr_pkg::VisWidthRst;
      vis_h_q <= fgr_pkg::VisHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fgr_pkg::RegOffsetX:   off_x_q <= cfg_wdata_i[6:0];
        fgr_pkg::RegOffsetY:   off_y_q <= cfg_wdata_i[5:0];
        fgr_pkg::RegVisWidth:  vis_w_q <= cfg_wdata_i;
        fgr_pkg::RegVisHeight: vis_h_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // per-byte glyph slice for the current column and page
  always_comb begin
    col  = bx_q + {6'd0, k_q};
    page = {1'b0, by_q[6:3]} + {4'd0, p_q};
    g0   = fgr_pkg::font_col(code_q, k_q);
    g1   = (k_q == 3'd0) ? 8'd0 : fgr_pkg::font_col(code_q, k_q - 3'd1);
    v    = scaled_q ? (g0 | g1) : g0;
    v9   = scaled_q ? ({v, 1'b0} | {1'b0, v}) : {1'b0, v};
    b16  = {7'd0, v9} << by_q[2:0];
    m16  = scaled_q ? b16 : (16'h00FF << by_q[2:0]);
    pg_b = p_q ? b16[15:8] : b16[7:0];
    pg_m = p_q ? m16[15:8] : m16[7:0];
    for (int n = 0; n < 8; n++) begin
      row_ok[n] = ({27'd0, page} * 32'd8 + 32'(n)) < PANEL_HEIGHT;
    end
    pos   = {27'd0, page} * PANEL_WIDTH + {23'd0, col};
    op_ok = ({23'd0, col} < PANEL_WIDTH) && (pos < StoreBytes);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fgr_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (fgr_pkg::func_e'(in_i.func))
            fgr_pkg::FUNC_DRAW,
            fgr_pkg::FUNC_SCALED: state_d = skip ? fgr_pkg::ST_DONE : fgr_pkg::ST_RD;
            fgr_pkg::FUNC_CLEAR:  state_d = fgr_pkg::ST_CLR;
            fgr_pkg::FUNC_READ:   state_d = rd_in_range ? fgr_pkg::ST_RDB : fgr_pkg::ST_DONE;
            default:              state_d = fgr_pkg::ST_DONE;
          endcase
        end
      end
      fgr_pkg::ST_CLR: begin
        if (cnt_q == Aw'(StoreBytes - 1)) begin
          state_d = clr_res_q ? fgr_pkg::ST_DONE : fgr_pkg::ST_IDLE;
        end
      end
      fgr_pkg::ST_RD:   state_d = fgr_pkg::ST_WR;
      fgr_pkg::ST_WR:   state_d = last_op ? fgr_pkg::ST_DONE : fgr_pkg::ST_RD;
      fgr_pkg::ST_RDB:  state_d = fgr_pkg::ST_DONE;
      fgr_pkg::ST_DONE: state_d = out_free ? fgr_pkg::ST_IDLE : fgr_pkg::ST_DONE;
      default:          state_d = fgr_pkg::ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    in_i.ready = (state_q == fgr_pkg::ST_IDLE);
    rd_addr    = (state_q == fgr_pkg::ST_RD) ? pos[Aw-1:0] : in_addr_ext[Aw-1:0];
    wr_en      = 1'b0;
    wr_addr    = op_addr_q;
    wr_mask    = op_mask_q;
    wr_bits    = op_bits_q;
    unique case (state_q)
      fgr_pkg::ST_CLR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q;
        wr_mask = 8'hFF;
        wr_bits = 8'h00;
      end
      fgr_pkg::ST_WR: wr_en = op_ok_q;
      default: ;
    endcase
  end

  // state and sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fgr_pkg::ST_CLR;
      cnt_q       <= '0;
      clr_res_q   <= 1'b0;
      k_q         <= 3'd0;
      p_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == fgr_pkg::ST_CLR) begin
        cnt_q <= cnt_q + Aw'(1);
      end
      if (in_acc) begin
        cnt_q     <= '0;
        clr_res_q <= 1'b1;
        k_q       <= 3'd0;
        p_q       <= 1'b0;
      end
      if (state_q == fgr_pkg::ST_WR) begin
        p_q <= !p_q;
        if (p_q) begin
          k_q <= k_q + 3'd1;
        end
      end
      if (state_q == fgr_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request payload, op and result registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      scaled_q     <= (in_i.func == fgr_pkg::FUNC_SCALED);
      code_q       <= in_i.char_code;
      bx_q         <= {2'd0, in_i.x_pos} + {2'd0, off_x_q};
      by_q         <= {1'b0, in_i.y_pos} + {1'b0, off_y_q};
      res_data_q   <= 8'd0;
      res_status_q <= ((in_i.func == fgr_pkg::FUNC_DRAW) ||
                       (in_i.func == fgr_pkg::FUNC_SCALED)) && skip;
    end
    if (state_q == fgr_pkg::ST_RD) begin
      op_ok_q   <= op_ok;
      op_addr_q <= pos[Aw-1:0];
      op_mask_q <= pg_m & row_ok;
      op_bits_q <= pg_b & row_ok;
    end
    if (state_q == fgr_pkg::ST_RDB) begin
      res_data_q <= rd_data;
    end
    if (state_q == fgr_pkg::ST_DONE && out_free) begin
      out_data_q   <= res_data_q;
      out_status_q <= res_status_q;
    end
  end

  fgr_store #(
    .Depth(StoreBytes),
    .Aw   (Aw)
  ) u_store (
    .clk_i    (clk_i),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_mask_i(wr_mask),
    .wr_bits_i(wr_bits)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;
  assign out_o.status    = out_status_q;

endmodule

[rtl/fgr_checker.sv]
// port-level assertions for the glyph framebuffer renderer and their binding
module fgr_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data,
  input logic       out_status
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_status))
    else $error("result changed while stalled");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a skipped draw never carries read data
  a_status_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status |-> out_data == 8'd0)
    else $error("skip status with read data");

  // the store sweep after reset blocks requests
  a_reset_busy: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready)
    else $error("request taken during reset sweep");

endmodule

bind font_glyph_framebuffer_render_top fgr_sva u_fgr_sva (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.read_data),
  .out_status(out_o.status)
);
